// ===== rtl/tfb_pkg.sv =====
// ----------------------------------------------------------------------------
// tfb_pkg
// Shared types, constants and the base throughput table for the transmit
// rate fallback block.
// ----------------------------------------------------------------------------
package tfb_pkg;

    localparam int COUNT_WIDTH_DEF = 16;

    localparam int NUM_RATES  = 12;
    localparam int TOTAL_SLOT = 12;
    localparam int NUM_SLOTS  = 13;
    localparam int RATE_W     = 4;
    localparam int TPUT_W     = 10;
    localparam int TICK_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [RATE_W-1:0] IDX_11M = 4'd3;
    localparam logic [RATE_W-1:0] IDX_6M  = 4'd4;

    localparam logic [NUM_RATES-1:0] AUTO_MASK = 12'hFCF;
    localparam logic [TICK_W-1:0]    TICK_MAX  = 16'hFFFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_MASK    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_5GHZ    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OK_THRESH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAIL_THRESH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 3'd4;

    localparam logic MODE_REPORT = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [RATE_W-1:0] rate_index;
        logic              success;
        logic              scanning;
    } req_t;

    typedef struct packed {
        logic [RATE_W-1:0] current_rate;
        logic              decided;
    } rsp_t;

    typedef struct packed {
        logic              clear;
        logic              bump;
        logic              success;
        logic [RATE_W-1:0] rate;
    } bank_ctrl_t;

    function automatic logic [TPUT_W-1:0] base_tput(input logic [RATE_W-1:0] idx);
        logic [TPUT_W-1:0] val;
        case (idx)
            4'd0:    val = 10'd10;
            4'd1:    val = 10'd20;
            4'd2:    val = 10'd55;
            4'd3:    val = 10'd110;
            4'd4:    val = 10'd60;
            4'd5:    val = 10'd90;
            4'd6:    val = 10'd120;
            4'd7:    val = 10'd180;
            4'd8:    val = 10'd240;
            4'd9:    val = 10'd360;
            4'd10:   val = 10'd480;
            4'd11:   val = 10'd540;
            default: val = 10'd0;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/tfb_count_bank.sv =====
// ----------------------------------------------------------------------------
// tfb_count_bank
// Saturating success and failure counters per rate plus the totals, with
// one selectable read port and a clear-all.
// ----------------------------------------------------------------------------
module tfb_count_bank #(
    parameter int COUNT_WIDTH = tfb_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tfb_pkg::bank_ctrl_t           ctrl,
    input  logic [tfb_pkg::RATE_W-1:0]    rd_addr,
    output logic [COUNT_WIDTH-1:0]        rd_ok,
    output logic [COUNT_WIDTH-1:0]        rd_fail,
    output logic [COUNT_WIDTH-1:0]        tot_ok,
    output logic [COUNT_WIDTH-1:0]        tot_fail
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0] ok_reg   [tfb_pkg::NUM_SLOTS];
    logic [COUNT_WIDTH-1:0] fail_reg [tfb_pkg::NUM_SLOTS];
    logic                   rate_ok;

    assign rate_ok = ctrl.rate < tfb_pkg::RATE_W'(tfb_pkg::NUM_RATES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tfb_pkg::NUM_SLOTS; i++)
            begin
                ok_reg[i]   <= '0;
                fail_reg[i] <= '0;
            end
        end
        else if (ctrl.clear)
        begin
            for (int i = 0; i < tfb_pkg::NUM_SLOTS; i++)
            begin
                ok_reg[i]   <= '0;
                fail_reg[i] <= '0;
            end
        end
        else if (ctrl.bump && rate_ok)
        begin
            for (int i = 0; i < tfb_pkg::NUM_SLOTS; i++)
            begin
                if ((ctrl.rate == tfb_pkg::RATE_W'(i)) || (i == tfb_pkg::TOTAL_SLOT))
                begin
                    if (ctrl.success)
                    begin
                        if (ok_reg[i] != CNT_MAX)
                            ok_reg[i] <= ok_reg[i] + 1'b1;
                    end
                    else
                    begin
                        if (fail_reg[i] != CNT_MAX)
                            fail_reg[i] <= fail_reg[i] + 1'b1;
                    end
                end
            end
        end
    end

    assign rd_ok    = ok_reg[rd_addr];
    assign rd_fail  = fail_reg[rd_addr];
    assign tot_ok   = ok_reg[tfb_pkg::TOTAL_SLOT];
    assign tot_fail = fail_reg[tfb_pkg::TOTAL_SLOT];

endmodule

// ===== rtl/tfb_tput_unit.sv =====
// ----------------------------------------------------------------------------
// tfb_tput_unit
// Shared throughput estimator: base * ok / (ok + w * fail), one multiply
// then a restoring division that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tfb_tput_unit #(
    parameter int COUNT_WIDTH = tfb_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tfb_pkg::TPUT_W-1:0]    base,
    input  logic                          heavy,
    input  logic [COUNT_WIDTH-1:0]        ok,
    input  logic [COUNT_WIDTH-1:0]        fail,
    output logic                          done,
    output logic [tfb_pkg::TPUT_W-1:0]    tput
);

    localparam int QW     = tfb_pkg::TPUT_W;
    localparam int NW     = COUNT_WIDTH + QW;
    localparam int DENW   = COUNT_WIDTH + 3;
    localparam int DW     = DENW + QW - 1;
    localparam int STEP_W = $clog2(QW);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QW - 1);

    logic [NW-1:0]     rem_reg;
    logic [DW-1:0]     dsh_reg;
    logic [QW-1:0]     q_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DENW-1:0]   den;
    logic [DENW-1:0]   fail_w;
    logic              fits;

    assign fail_w = heavy ? {1'b0, fail, 2'b00} : DENW'(fail);
    assign den    = DENW'(ok) + fail_w;
    assign fits   = DW'(rem_reg) >= dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                step_reg <= '0;
                // no outcomes: keep the base value
                if (ok == '0 && fail == '0)
                    done_reg <= 1'b1;
                else
                    busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= NW'(base) * NW'(ok);
            dsh_reg <= DW'(den) << (QW - 1);
            q_reg   <= base;
        end
        else if (busy_reg)
        begin
            if (fits)
                rem_reg <= rem_reg - dsh_reg[NW-1:0];
            q_reg   <= {q_reg[QW-2:0], fits};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign done = done_reg;
    assign tput = q_reg;

endmodule

// ===== rtl/tx_rate_fallback.sv =====
// ----------------------------------------------------------------------------
// tx_rate_fallback
// Transmit rate adaptation over 12 rate indices: outcome counters, tick
// timeout and a throughput-based drop / clean-link climb decision.
// ----------------------------------------------------------------------------
// A report passes S_REPORT and an undecided tick S_TICK before S_DONE
// registers its word; a tick during a scan goes straight to S_DONE. A decision
// walks the rates from the current one down to 0 through the shared throughput
// unit, S_LOAD and S_WAIT per rate, then clears the counters in S_APPLY.
// Throughput: one word in flight; the next is taken once the result is loaded.
// Reset: counters and tick clear, rate goes to index 0, registers to defaults.
// ----------------------------------------------------------------------------
module tx_rate_fallback #(
    parameter int COUNT_WIDTH = tfb_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  tfb_pkg::req_t                     req_data,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output tfb_pkg::rsp_t                     rsp_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tfb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tfb_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CMPW = (COUNT_WIDTH > tfb_pkg::TICK_W) ? COUNT_WIDTH : tfb_pkg::TICK_W;
    localparam int RW   = tfb_pkg::RATE_W;
    localparam int NR   = tfb_pkg::NUM_RATES;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_REPORT = 3'd1;
    localparam logic [2:0] S_TICK   = 3'd2;
    localparam logic [2:0] S_LOAD   = 3'd3;
    localparam logic [2:0] S_WAIT   = 3'd4;
    localparam logic [2:0] S_APPLY  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]                    state_reg;
    logic [2:0]                    state_next;
    tfb_pkg::req_t                 item_reg;
    logic [RW-1:0]                 idx_reg;
    logic [RW-1:0]                 down_reg;
    logic [tfb_pkg::TPUT_W-1:0]    best_reg;
    logic                          first_reg;
    logic                          decided_reg;
    logic [tfb_pkg::TICK_W-1:0]    tick_reg;
    logic [RW-1:0]                 data_rate_reg;
    logic                          rsp_valid_reg;
    tfb_pkg::rsp_t                 rsp_data_reg;

    logic [NR-1:0]                 rate_mask_reg;
    logic                          band_5ghz_reg;
    logic [tfb_pkg::TICK_W-1:0]    ok_thresh_reg;
    logic [tfb_pkg::TICK_W-1:0]    fail_thresh_reg;
    logic [tfb_pkg::TICK_W-1:0]    timeout_reg;

    tfb_pkg::bank_ctrl_t           bank_ctrl;
    logic [COUNT_WIDTH-1:0]        rd_ok;
    logic [COUNT_WIDTH-1:0]        rd_fail;
    logic [COUNT_WIDTH-1:0]        tot_ok;
    logic [COUNT_WIDTH-1:0]        tot_fail;
    logic                          tput_done;
    logic [tfb_pkg::TPUT_W-1:0]    tput;

    logic [NR-1:0]                 auto_set;
    logic [RW-1:0]                 up_rate;
    logic [tfb_pkg::TICK_W-1:0]    tick_inc;
    logic [COUNT_WIDTH-1:0]        fail_diff;
    logic                          trigger;
    logic                          go_up;
    logic [RW-1:0]                 pick_rate;
    logic [RW-1:0]                 final_rate;
    logic                          take_rsp;
    logic                          better;

    // ---------------- shared datapath ----------------
    tfb_count_bank #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_bank (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (bank_ctrl),
        .rd_addr  (idx_reg),
        .rd_ok    (rd_ok),
        .rd_fail  (rd_fail),
        .tot_ok   (tot_ok),
        .tot_fail (tot_fail)
    );

    tfb_tput_unit #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_tput (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_LOAD),
        .base  (tfb_pkg::base_tput(idx_reg)),
        .heavy (idx_reg < tfb_pkg::IDX_11M),
        .ok    (rd_ok),
        .fail  (rd_fail),
        .done  (tput_done),
        .tput  (tput)
    );

    always_comb
    begin
        bank_ctrl         = '0;
        bank_ctrl.clear   = (state_reg == S_APPLY);
        bank_ctrl.bump    = (state_reg == S_REPORT);
        bank_ctrl.success = item_reg.success;
        bank_ctrl.rate    = item_reg.rate_index;
    end

    // ---------------- decision helpers ----------------
    assign auto_set = tfb_pkg::AUTO_MASK & rate_mask_reg;

    always_comb
    begin
        up_rate = '0;
        for (int i = 0; i < NR; i++)
        begin
            if (auto_set[i])
                up_rate = RW'(i);
        end
    end

    assign tick_inc  = (tick_reg == tfb_pkg::TICK_MAX) ? tick_reg : tick_reg + 1'b1;
    assign fail_diff = (tot_fail > tot_ok) ? (tot_fail - tot_ok) : '0;
    assign trigger   = !((CMPW'(tot_ok) < CMPW'(ok_thresh_reg)) &&
                         (CMPW'(fail_diff) < CMPW'(fail_thresh_reg)) &&
                         (tick_inc < timeout_reg));

    assign go_up = (tot_ok != '0) ? ((COUNT_WIDTH+2)'(tot_ok) > {tot_fail, 2'b00})
                                  : (tot_fail == '0);
    assign pick_rate  = go_up ? up_rate : down_reg;
    assign final_rate = (band_5ghz_reg && pick_rate <= tfb_pkg::IDX_11M) ? tfb_pkg::IDX_6M
                                                                         : pick_rate;

    assign better   = (tput > best_reg) && auto_set[idx_reg];
    assign take_rsp = !rsp_valid_reg || !rsp_stall;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_data.mode == tfb_pkg::MODE_REPORT)
                        state_next = S_REPORT;
                    else if (req_data.scanning)
                        state_next = S_DONE;
                    else
                        state_next = S_TICK;
                end
            end
            S_REPORT: state_next = S_DONE;
            S_TICK:   state_next = trigger ? S_LOAD : S_DONE;
            S_LOAD:   state_next = S_WAIT;
            S_WAIT:
            begin
                if (tput_done)
                    state_next = (idx_reg == '0) ? S_APPLY : S_LOAD;
            end
            S_APPLY:  state_next = S_DONE;
            S_DONE:
            begin
                if (take_rsp)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            decided_reg   <= 1'b0;
            first_reg     <= 1'b0;
            idx_reg       <= '0;
            tick_reg      <= '0;
            data_rate_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    decided_reg <= 1'b0;
                end
                S_TICK:
                begin
                    // timeout clears the tick counter
                    if (trigger && tick_inc >= timeout_reg)
                        tick_reg <= '0;
                    else
                        tick_reg <= tick_inc;
                    idx_reg   <= data_rate_reg;
                    first_reg <= 1'b1;
                end
                S_WAIT:
                begin
                    if (tput_done)
                    begin
                        first_reg <= 1'b0;
                        if (idx_reg != '0)
                            idx_reg <= idx_reg - 1'b1;
                    end
                end
                S_APPLY:
                begin
                    data_rate_reg <= final_rate;
                    decided_reg   <= 1'b1;
                end
                default:
                begin
                end
            endcase

            if (state_reg == S_DONE && take_rsp)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req_valid)
            item_reg <= req_data;
        if (state_reg == S_WAIT && tput_done && (first_reg || better))
        begin
            best_reg <= tput;
            down_reg <= idx_reg;
        end
        if (state_reg == S_DONE && take_rsp)
        begin
            rsp_data_reg.current_rate <= data_rate_reg;
            rsp_data_reg.decided      <= decided_reg;
        end
    end

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_mask_reg   <= {NR{1'b1}};
            band_5ghz_reg   <= 1'b0;
            ok_thresh_reg   <= 16'd100;
            fail_thresh_reg <= 16'd10;
            timeout_reg     <= 16'd10;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tfb_pkg::CFG_RATE_MASK:   rate_mask_reg   <= cfg_data[NR-1:0];
                tfb_pkg::CFG_BAND_5GHZ:   band_5ghz_reg   <= cfg_data[0];
                tfb_pkg::CFG_OK_THRESH:   ok_thresh_reg   <= cfg_data;
                tfb_pkg::CFG_FAIL_THRESH: fail_thresh_reg <= cfg_data;
                tfb_pkg::CFG_TIMEOUT:     timeout_reg     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // ---------------- assertions ----------------
    a_clear_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY) |=> (tot_ok == '0 && tot_fail == '0))
        else $error("counters not cleared after decision");

    a_done_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        tput_done |-> (state_reg == S_WAIT))
        else $error("throughput result outside wait state");

    a_rate_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY) |=> (data_rate_reg < RW'(NR)))
        else $error("decided rate out of range");

    a_report_no_decision: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REPORT) |=> !decided_reg)
        else $error("report flagged as decision");

endmodule
